// File: design/aps_pkg.sv
// Shared types and constants for the aurora pixel shader.
`timescale 1ns / 1ps
package aps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W    = 10;
    localparam int TIME_W     = 15;
    localparam int CHAN_W     = 8;

    typedef logic signed [15:0] t_sine;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SPEED,
        CFG_BREATH_SPEED,
        CFG_RED_BASE,
        CFG_RED_SPAN,
        CFG_GREEN_BASE,
        CFG_GREEN_SPAN,
        CFG_BLUE_BASE,
        CFG_BLUE_SPAN
    } t_cfg_idx;

    // radians in Q28
    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    // 1/(2*pi) in Q32
    localparam longint INV_TWO_PI_Q32 = 683565276;

    // per-column phase slopes, radians Q24
    localparam int COEF_S1 = 251658;
    localparam int COEF_S2 = 167772;
    localparam int COEF_SB = 1677722;
    localparam int COEF_SC = 838861;
    localparam int COEF_SE = 50332;

    // sine lanes
    localparam int N_SINES = 8;
    localparam int SIN_S1  = 0;
    localparam int SIN_S2  = 1;
    localparam int SIN_SA  = 2;
    localparam int SIN_SB  = 3;
    localparam int SIN_SC  = 4;
    localparam int SIN_SD  = 5;
    localparam int SIN_SE  = 6;
    localparam int SIN_BR  = 7;

endpackage

// File: design/aps_sine_rom.sv
// Dual read port sine table over one full turn, Q1.15, registered reads.
`timescale 1ns / 1ps
module aps_sine_rom #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [$clog2(SINE_ENTRIES)-1:0] i_addr_a,
    input  logic [$clog2(SINE_ENTRIES)-1:0] i_addr_b,
    output aps_pkg::t_sine                  o_data_a,
    output aps_pkg::t_sine                  o_data_b
);
    import aps_pkg::*;

    typedef t_sine t_rom [SINE_ENTRIES];

    function automatic longint sq_step(input longint term, input longint x);
        longint t;
        t = (term * x) >>> 28;
        t = (t * x) >>> 28;
        return t;
    endfunction

    function automatic t_sine sine_entry(input longint k);
        longint x;
        longint sum;
        longint term;
        logic   neg;
        x   = (k * 2 * PI_Q28) / SINE_ENTRIES;
        neg = 1'b0;
        if (x >= PI_Q28) begin
            x   = x - PI_Q28;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q28) x = PI_Q28 - x;
        sum  = x;
        term = sq_step(x, x) / 6;
        sum  = sum - term;
        term = sq_step(term, x) / 20;
        sum  = sum + term;
        term = sq_step(term, x) / 42;
        sum  = sum - term;
        term = sq_step(term, x) / 72;
        sum  = sum + term;
        term = sq_step(term, x) / 110;
        sum  = sum - term;
        term = sq_step(term, x) / 156;
        sum  = sum + term;
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 28)) sum = longint'(1) << 28;
        sum = (sum * 32767 + (longint'(1) << 27)) >>> 28;
        return neg ? t_sine'(-sum) : t_sine'(sum);
    endfunction

    function automatic t_rom build_rom();
        t_rom tab;
        for (int k = 0; k < SINE_ENTRIES; k++) tab[k] = sine_entry(longint'(k));
        return tab;
    endfunction

    localparam t_rom C_ROM = build_rom();

    t_sine r_data_a;
    t_sine r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= C_ROM[i_addr_a];
            r_data_b <= C_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// File: design/aurora_pixel_shader.sv
// Top level of the aurora pixel shader: config registers and pixel pipeline.
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the output is not stalled; every
// stage holds its own valid bit and advances whenever its successor frees,
// so bubbles close up under stall.
// Eight sine lookups per pixel use four dual-port table copies.
// Reset (synchronous, active low) clears the pipeline valids and loads the
// speed registers with 1.0 and the colour registers with zero.
module aurora_pixel_shader #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320,
    parameter int SINE_ENTRIES  = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [aps_pkg::COORD_W-1:0]    i_column,
    input  logic [aps_pkg::COORD_W-1:0]    i_row,
    input  logic [aps_pkg::TIME_W-1:0]     i_frame_time,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [aps_pkg::CHAN_W-1:0]     o_red,
    output logic [aps_pkg::CHAN_W-1:0]     o_green,
    output logic [aps_pkg::CHAN_W-1:0]     o_blue
);
    import aps_pkg::*;

    localparam int NS        = 15;
    localparam int AW        = $clog2(SINE_ENTRIES);
    localparam int C_CENTRE  = SCREEN_HEIGHT * 24576;
    localparam int C_RECIP_H = (1 << 30) / SCREEN_HEIGHT;
    localparam int C_RECIP_W = (1 << 24) / SCREEN_WIDTH;
    localparam int C_SAT_W   = 256 * SCREEN_WIDTH;

    // configuration
    logic [15:0]       r_wave_speed;
    logic [15:0]       r_breath_speed;
    logic [7:0]        r_base [3];
    logic signed [8:0] r_span [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_speed   <= 16'd4096;
            r_breath_speed <= 16'd4096;
            for (int c = 0; c < 3; c++) begin
                r_base[c] <= '0;
                r_span[c] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WAVE_SPEED:   r_wave_speed   <= i_cfg_data;
                CFG_BREATH_SPEED: r_breath_speed <= i_cfg_data;
                CFG_RED_BASE:     r_base[0] <= i_cfg_data[7:0];
                CFG_RED_SPAN:     r_span[0] <= i_cfg_data[8:0];
                CFG_GREEN_BASE:   r_base[1] <= i_cfg_data[7:0];
                CFG_GREEN_SPAN:   r_span[1] <= i_cfg_data[8:0];
                CFG_BLUE_BASE:    r_base[2] <= i_cfg_data[7:0];
                CFG_BLUE_SPAN:    r_span[2] <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NS:1] r_vld;
    logic [NS:1] n_vprev;
    logic [NS:1] n_en;

    assign n_vprev = {r_vld[NS-1:1], i_valid};
    assign n_en[NS] = !r_vld[NS] || i_ready;
    for (genvar k = 1; k < NS; k++) begin : g_en
        assign n_en[k] = !r_vld[k] || n_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (n_en[k]) r_vld[k] <= n_vprev[k];
            end
        end
    end

    assign o_ready = n_en[1];
    assign o_valid = r_vld[NS];

    // coordinate delay lines
    logic [9:0] r_col [1:11];
    logic [9:0] r_row [1:6];

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_col[1] <= i_column;
            r_row[1] <= i_row;
        end
        for (int k = 2; k <= 11; k++) begin
            if (n_en[k]) r_col[k] <= r_col[k-1];
        end
        for (int k = 2; k <= 6; k++) begin
            if (n_en[k]) r_row[k] <= r_row[k-1];
        end
    end

    // P1: scaled times
    logic [30:0] r_p1_t;
    logic [30:0] r_p1_b;

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_p1_t <= 31'(32'(i_frame_time) * 32'(r_wave_speed));
            r_p1_b <= 31'(32'(i_frame_time) * 32'(r_breath_speed));
        end
    end

    // P2: phase angles, radians Q24
    logic [34:0] n_ang [N_SINES];
    logic [34:0] r_p2_ang [N_SINES];

    always_comb begin
        n_ang[SIN_S1] = 35'(r_col[1]) * 35'(COEF_S1) + 35'(r_p1_t);
        n_ang[SIN_S2] = 35'(r_col[1]) * 35'(COEF_S2) + 35'(r_p1_t >> 1);
        n_ang[SIN_SA] = (35'(r_col[1]) << 24) + 35'(r_p1_t);
        n_ang[SIN_SB] = 35'(r_col[1]) * 35'(COEF_SB) + 35'(r_p1_t);
        n_ang[SIN_SC] = 35'(r_col[1]) * 35'(COEF_SC) + 35'((33'(r_p1_t) * 33'd3) >> 2);
        n_ang[SIN_SD] = 35'(r_col[1]) * 35'(COEF_S2) + 35'(r_p1_t);
        n_ang[SIN_SE] = 35'(r_col[1]) * 35'(COEF_SE)
                      + 35'((46'(r_p1_t) * 46'd19661) >> 16);
        n_ang[SIN_BR] = 35'(r_p1_b);
    end

    // P3: turns Q0.32, P4: table index
    logic [31:0]   n_turn [N_SINES];
    logic [31:0]   r_p3_turn [N_SINES];
    logic [AW-1:0] n_idx [N_SINES];
    logic [AW-1:0] r_p4_idx [N_SINES];

    always_comb begin
        for (int i = 0; i < N_SINES; i++) begin
            n_turn[i] = 32'((66'(r_p2_ang[i]) * 66'(INV_TWO_PI_Q32)) >> 24);
            n_idx[i]  = AW'((45'(r_p3_turn[i]) * 45'(SINE_ENTRIES)) >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_SINES; i++) begin
            if (n_en[2]) r_p2_ang[i]  <= n_ang[i];
            if (n_en[3]) r_p3_turn[i] <= n_turn[i];
            if (n_en[4]) r_p4_idx[i]  <= n_idx[i];
        end
    end

    // P5: sine lookups
    t_sine n_sin [N_SINES];

    for (genvar j = 0; j < N_SINES / 2; j++) begin : g_rom
        aps_sine_rom #(
            .SINE_ENTRIES(SINE_ENTRIES)
        ) u_rom (
            .i_clk    (i_clk),
            .i_en     (n_en[5]),
            .i_addr_a (r_p4_idx[2*j]),
            .i_addr_b (r_p4_idx[2*j+1]),
            .o_data_a (n_sin[2*j]),
            .o_data_b (n_sin[2*j+1])
        );
    end

    // P6: noise and breathing
    logic signed [31:0] n_bc;
    logic signed [17:0] n_noise;
    logic [33:0]        n_brp;
    logic [16:0]        n_breath;
    t_sine              r_p6_s1, r_p6_s2, r_p6_sd, r_p6_se;
    logic signed [17:0] r_p6_noise;
    logic [16:0]        r_p6_breath;

    always_comb begin
        n_bc     = n_sin[SIN_SB] * n_sin[SIN_SC];
        n_noise  = 18'(n_sin[SIN_SA] >>> 1) + 18'(n_bc >>> 15);
        n_brp    = 34'({~n_sin[SIN_BR][15], n_sin[SIN_BR][14:0]}) * 34'd104858;
        n_breath = n_brp[32:16];
        if (n_breath < 17'd13107) n_breath = 17'd13107;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r_p6_s1     <= n_sin[SIN_S1];
            r_p6_s2     <= n_sin[SIN_S2];
            r_p6_sd     <= n_sin[SIN_SD];
            r_p6_se     <= n_sin[SIN_SE];
            r_p6_noise  <= n_noise;
            r_p6_breath <= n_breath;
        end
    end

    // P7: distance to centre line, wave sum
    logic signed [27:0] n_cen;
    logic signed [27:0] n_d;
    logic signed [33:0] n_nw;
    logic signed [18:0] n_wsum;
    logic signed [27:0] r_p7_d;
    logic signed [18:0] r_p7_wsum;
    logic [16:0]        r_p7_breath;

    always_comb begin
        n_cen  = 28'(C_CENTRE) + 28'(r_p6_s1) * 28'sd40 + 28'(r_p6_s2) * 28'sd20
               + 28'(r_p6_noise) * 28'sd10;
        n_d    = $signed({3'b000, r_row[6], 15'd0}) - n_cen;
        n_nw   = 34'(r_p6_noise) * 34'sd19661;
        n_wsum = 19'(r_p6_sd) + 19'(r_p6_se) + 19'(n_nw >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[7]) begin
            r_p7_d      <= n_d;
            r_p7_wsum   <= n_wsum;
            r_p7_breath <= r_p6_breath;
        end
    end

    // P8: |4d| times reciprocal of height, brightness
    logic signed [29:0] n_d4;
    logic [29:0]        n_abs;
    logic signed [34:0] n_wv;
    logic signed [19:0] n_bright;
    logic [29:0]        r_p8_abs;
    logic               r_p8_neg;
    logic [56:0]        r_p8_prod;
    logic [16:0]        r_p8_bright;
    logic [16:0]        r_p8_breath;

    always_comb begin
        n_d4     = 30'(r_p7_d) <<< 2;
        n_abs    = n_d4[29] ? 30'(-n_d4) : 30'(n_d4);
        n_wv     = 35'(r_p7_wsum) * 35'sd21627;
        n_bright = 20'(n_wv >>> 16) + 20'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[8]) begin
            r_p8_abs    <= n_abs;
            r_p8_neg    <= n_d4[29];
            r_p8_prod   <= 57'(n_abs) * 57'(C_RECIP_H);
            r_p8_bright <= n_bright[16:0];
            r_p8_breath <= r_p7_breath;
        end
    end

    // P9: quotient correction, bright * breath
    logic [26:0] n_qa;
    logic [30:0] n_rem;
    logic [26:0] n_q;
    logic [33:0] n_bb;
    logic [26:0] r_p9_q;
    logic        r_p9_neg;
    logic [16:0] r_p9_bb;

    always_comb begin
        n_qa  = 27'(r_p8_prod >> 30);
        n_rem = 31'(r_p8_abs) - 31'(40'(n_qa) * 40'(SCREEN_HEIGHT));
        n_q   = (n_rem >= 31'(SCREEN_HEIGHT)) ? n_qa + 27'd1 : n_qa;
        n_bb  = 34'(r_p8_bright) * 34'(r_p8_breath);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[9]) begin
            r_p9_q   <= n_q;
            r_p9_neg <= r_p8_neg;
            r_p9_bb  <= n_bb[32:16];
        end
    end

    // P10: gradient clamp and square
    logic [16:0] n_g;
    logic [33:0] n_gg;
    logic [16:0] r_p10_g2;
    logic [16:0] r_p10_bb;

    always_comb begin
        if (r_p9_neg)                   n_g = 17'd65536;
        else if (r_p9_q >= 27'd65536)   n_g = 17'd0;
        else                            n_g = 17'(27'd65536 - r_p9_q);
        n_gg = 34'(n_g) * 34'(n_g);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[10]) begin
            r_p10_g2 <= n_gg[32:16];
            r_p10_bb <= r_p9_bb;
        end
    end

    // P11: intensity
    logic [33:0] n_ip;
    logic [16:0] n_inten;
    logic [16:0] r_p11_inten;

    always_comb begin
        n_ip    = 34'(r_p10_bb) * 34'(r_p10_g2);
        n_inten = n_ip[32:16];
        if (n_inten < 17'd3277) n_inten = 17'd5243;
    end

    always_ff @(posedge i_clk) begin
        if (n_en[11]) r_p11_inten <= n_inten;
    end

    // P12..P15: colour channels
    logic signed [20:0] n_num [3];
    logic signed [20:0] r_p12_num [3];
    logic [16:0]        r_p12_inten;
    logic signed [38:0] r_p13_p [3];
    logic [22:0]        n_n [3];
    logic [22:0]        r_p14_n [3];
    logic               r_p14_neg [3];
    logic               r_p14_sat [3];
    logic [43:0]        r_p14_prod [3];
    logic [19:0]        n_cq [3];
    logic [23:0]        n_crem [3];
    logic [19:0]        n_cqc [3];
    logic [7:0]         r_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_num[c]  = 21'($signed({1'b0, r_base[c]})) * 21'(SCREEN_WIDTH)
                      + 21'(r_span[c]) * 21'($signed({1'b0, r_col[11]}));
            n_n[c]    = r_p13_p[c][38:16];
            n_cq[c]   = 20'(r_p14_prod[c] >> 24);
            n_crem[c] = 24'(r_p14_n[c]) - 24'(32'(n_cq[c]) * 32'(SCREEN_WIDTH));
            n_cqc[c]  = (n_crem[c] >= 24'(SCREEN_WIDTH)) ? n_cq[c] + 20'd1 : n_cq[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[12]) r_p12_inten <= r_p11_inten;
        for (int c = 0; c < 3; c++) begin
            if (n_en[12]) r_p12_num[c] <= n_num[c];
            if (n_en[13]) r_p13_p[c] <= 39'($signed({1'b0, r_p12_inten})) * 39'(r_p12_num[c]);
            if (n_en[14]) begin
                r_p14_n[c]    <= n_n[c];
                r_p14_neg[c]  <= r_p13_p[c][38];
                r_p14_sat[c]  <= 32'(n_n[c]) >= 32'(C_SAT_W);
                r_p14_prod[c] <= 44'(n_n[c]) * 44'(C_RECIP_W);
            end
            if (n_en[15]) begin
                if (r_p14_neg[c])      r_out[c] <= 8'd0;
                else if (r_p14_sat[c]) r_out[c] <= 8'd255;
                else                   r_out[c] <= n_cqc[c][7:0];
            end
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// File: tb/tb_aurora_pixel_shader.sv
// Self-checking testbench for the aurora pixel shader: directed table, random pixels, stalls.
`timescale 1ns / 1ps
module tb_aurora_pixel_shader;
    import aps_pkg::*;

    localparam int W = 480;
    localparam int H = 320;
    localparam int NSIN = 1024;
    localparam int LATENCY = 15;
    localparam int N_RANDOM = 1030;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [TIME_W-1:0]  frame_time;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct {
        t_pixel px;
        bit     has_rgb;
        t_rgb   rgb;
    } t_row_entry;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [COORD_W-1:0]    i_column;
    logic [COORD_W-1:0]    i_row;
    logic [TIME_W-1:0]     i_frame_time;
    logic                  o_valid;
    logic                  i_ready;
    logic [CHAN_W-1:0]     o_red;
    logic [CHAN_W-1:0]     o_green;
    logic [CHAN_W-1:0]     o_blue;

    aurora_pixel_shader dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_column(i_column), .i_row(i_row), .i_frame_time(i_frame_time),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue)
    );

    // shader register copy
    logic [15:0] wave_spd, breath_spd;
    logic [7:0]  base_r, base_g, base_b;
    logic [8:0]  span_r, span_g, span_b;

    t_sine  sine_lut [NSIN];
    t_rgb   rgb_queue[$];
    int     err_count;
    bit     rx_hold;
    bit     calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_aurora_pixel_shader: done, errors");
        $finish;
    end

    function automatic longint floor_sh(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic t_sine lut_entry(longint k);
        longint x, s, term;
        bit     neg;
        x = (k * (2 * PI_Q28)) / NSIN;
        neg = 1'b0;
        if (x >= PI_Q28) begin
            x -= PI_Q28;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q28) x = PI_Q28 - x;
        s = x;
        term = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >>> 28;
            term = (term * x) >>> 28;
            term = term / ((2 * n) * (2 * n + 1));
            s = (n & 1) ? s - term : s + term;
        end
        if (s < 0) s = 0;
        if (s > (longint'(1) << 28)) s = longint'(1) << 28;
        s = (s * 32767 + (longint'(1) << 27)) >>> 28;
        return neg ? t_sine'(-s) : t_sine'(s);
    endfunction

    function automatic longint sine_of(logic [63:0] angle);
        logic [63:0] prod;
        logic [31:0] turn;
        prod = angle * 64'(INV_TWO_PI_Q32);
        turn = prod[55:24];
        return longint'(sine_lut[(64'(turn) * NSIN) >> 32]);
    endfunction

    function automatic logic [7:0] shade(longint inten, logic [7:0] base, logic [8:0] span,
                                         longint col);
        longint num, c;
        num = longint'(base) * W + longint'($signed(span)) * col;
        c = (inten * num) / (longint'(W) * 65536);
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        return 8'(c);
    endfunction

    function automatic t_rgb shade_pixel(t_pixel px);
        logic [63:0] col, t, tw, tb;
        longint s1, s2, sa, sb, sc, sd, se, noise, centre, d, g, g2, wave, bright, breath, inten;
        t_rgb   rgb;
        col = 64'(px.column);
        t = 64'(px.frame_time);
        tw = t * wave_spd;
        tb = t * breath_spd;
        s1 = sine_of(col * COEF_S1 + tw);
        s2 = sine_of(col * COEF_S2 + (tw >> 1));
        sa = sine_of((col << 24) + tw);
        sb = sine_of(col * COEF_SB + tw);
        sc = sine_of(col * COEF_SC + ((tw * 3) >> 2));
        sd = sine_of(col * COEF_S2 + tw);
        se = sine_of(col * COEF_SE + ((tw * 19661) >> 16));
        noise = floor_sh(sa, 1) + floor_sh(sb * sc, 15);
        centre = longint'(H) * 24576 + 40 * s1 + 20 * s2 + 10 * noise;
        d = (longint'(px.row) << 15) - centre;
        g = 65536 - (4 * d) / H;
        if (g < 0) g = 0;
        if (g > 65536) g = 65536;
        g2 = (g * g) >> 16;
        wave = floor_sh((sd + se + floor_sh(noise * 19661, 16)) * 21627, 16);
        bright = wave + 32768;
        breath = ((sine_of(tb) + 32768) * 104858) >> 16;
        if (breath < 13107) breath = 13107;
        inten = (((bright * breath) >> 16) * g2) >> 16;
        if (inten < 3277) inten = 5243;
        rgb.red   = shade(inten, base_r, span_r, longint'(col));
        rgb.green = shade(inten, base_g, span_g, longint'(col));
        rgb.blue  = shade(inten, base_b, span_b, longint'(col));
        return rgb;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        err_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_WAVE_SPEED:   wave_spd   = value;
            CFG_BREATH_SPEED: breath_spd = value;
            CFG_RED_BASE:     base_r     = value[7:0];
            CFG_RED_SPAN:     span_r     = value[8:0];
            CFG_GREEN_BASE:   base_g     = value[7:0];
            CFG_GREEN_SPAN:   span_g     = value[8:0];
            CFG_BLUE_BASE:    base_b     = value[7:0];
            CFG_BLUE_SPAN:    span_b     = value[8:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_colors(logic [7:0] rb, logic [8:0] rs, logic [7:0] gb, logic [8:0] gs,
                               logic [7:0] bb, logic [8:0] bs);
        write_reg(CFG_RED_BASE, 16'(rb));
        write_reg(CFG_RED_SPAN, 16'(rs));
        write_reg(CFG_GREEN_BASE, 16'(gb));
        write_reg(CFG_GREEN_SPAN, 16'(gs));
        write_reg(CFG_BLUE_BASE, 16'(bb));
        write_reg(CFG_BLUE_SPAN, 16'(bs));
    endtask

    // one request; valid held until accepted, optional idle gap after
    task automatic send_pixel(t_pixel px, t_rgb rgb);
        rgb_queue.push_back(rgb);
        i_valid      <= 1'b1;
        i_column     <= px.column;
        i_row        <= px.row;
        i_frame_time <= px.frame_time;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        while (rgb_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        if ($urandom_range(9) == 0) begin
            px.column = 10'($urandom);
            px.row    = 10'($urandom);
        end else begin
            px.column = 10'($urandom_range(W - 1));
            px.row    = 10'($urandom_range(H - 1));
        end
        px.frame_time = 15'($urandom);
        return px;
    endfunction

    // receiver: random stall, or a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !rx_hold && (calm || $urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && i_ready) begin
            if (rgb_queue.size() == 0) begin
                report("unexpected result", o_red, 8'd0);
            end else begin
                want = rgb_queue.pop_front();
                if (o_red !== want.red)     report("red", o_red, want.red);
                if (o_green !== want.green) report("green", o_green, want.green);
                if (o_blue !== want.blue)   report("blue", o_blue, want.blue);
            end
        end
    end

    initial begin
        t_row_entry dir_table[$];
        t_row_entry e;
        t_rgb       rgb;
        for (int k = 0; k < NSIN; k++) sine_lut[k] = lut_entry(k);
        err_count    = 0;
        rx_hold      = 1'b0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_column     = '0;
        i_row        = '0;
        i_frame_time = '0;
        wave_spd = 16'd4096; breath_spd = 16'd4096;
        base_r = 0; base_g = 0; base_b = 0;
        span_r = 0; span_g = 0; span_b = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset all colors are zero
        dir_table.push_back('{'{10'd0, 10'd0, 15'd0}, 1'b1, '0});
        dir_table.push_back('{'{10'd1023, 10'd1023, 15'd32767}, 1'b1, '0});
        foreach (dir_table[k]) send_pixel(dir_table[k].px, dir_table[k].rgb);
        i_valid <= 1'b0;
        drain();
        dir_table.delete();

        load_colors(8'd255, 9'd255, 8'd0, 9'h101, 8'd128, 9'h1FF);
        dir_table.push_back('{'{10'd0, 10'd0, 15'd0}, 1'b0, '0});
        dir_table.push_back('{'{10'd479, 10'd319, 15'd32767}, 1'b0, '0});
        dir_table.push_back('{'{10'd1023, 10'd0, 15'd0}, 1'b0, '0});
        dir_table.push_back('{'{10'd0, 10'd1023, 15'd16384}, 1'b0, '0});
        dir_table.push_back('{'{10'd1023, 10'd1023, 15'd32767}, 1'b0, '0});
        dir_table.push_back('{'{10'd240, 10'd100, 15'd4096}, 1'b0, '0});
        dir_table.push_back('{'{10'd240, 10'd160, 15'd12000}, 1'b0, '0});
        dir_table.push_back('{'{10'h2AA, 10'h155, 15'h5555}, 1'b0, '0});
        dir_table.push_back('{'{10'h155, 10'h2AA, 15'h2AAA}, 1'b0, '0});
        foreach (dir_table[k]) begin
            e = dir_table[k];
            send_pixel(e.px, e.has_rgb ? e.rgb : shade_pixel(e.px));
        end
        i_valid <= 1'b0;
        drain();

        write_reg(CFG_WAVE_SPEED, 16'hFFFF);
        write_reg(CFG_BREATH_SPEED, 16'd0);
        load_colors(8'd0, 9'h101, 8'd255, 9'd255, 8'd255, 9'h1FF);
        foreach (dir_table[k]) send_pixel(dir_table[k].px, shade_pixel(dir_table[k].px));
        i_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_WAVE_SPEED, 16'd4096); write_reg(CFG_BREATH_SPEED, 16'd4096); end
                1: begin write_reg(CFG_WAVE_SPEED, 16'd0); write_reg(CFG_BREATH_SPEED, 16'hFFFF); end
                default: begin
                    write_reg(CFG_WAVE_SPEED, 16'($urandom));
                    write_reg(CFG_BREATH_SPEED, 16'($urandom));
                end
            endcase
            load_colors(8'($urandom), 9'($urandom), 8'($urandom), 9'($urandom),
                        8'($urandom), 9'($urandom));
            calm = (ph == 2);
            if (ph == 3) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (200) @(posedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                e.px = rand_pixel();
                rgb = shade_pixel(e.px);
                send_pixel(e.px, rgb);
            end
            i_valid <= 1'b0;
            calm = 1'b0;
            drain();
        end

        if (err_count == 0) begin
            $display("tb_aurora_pixel_shader: done, clean");
        end else begin
            $display("tb_aurora_pixel_shader: done, errors");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/aps_pkg.sv
design/aps_sine_rom.sv
design/aurora_pixel_shader.sv
tb/tb_aurora_pixel_shader.sv
